// ===== sv/htf_pkg.sv =====
// Package for the handle table with free-slot stack.
// Request/response structs, opcodes, status codes and register indexes.
// Used by handle_table_freelist_core; depends on nothing.
`default_nettype none

package htf_pkg;

  // Default number of table slots
  localparam int unsigned TABLE_SLOTS_DEF = 256;

  // Number of reserved standard console slots at the bottom of the table
  localparam int unsigned STD_SLOTS = 3;

  // Descriptor value that marks a shared page mapping (-42)
  localparam logic [31:0] DESC_SHARED_PAGE = 32'hFFFF_FFD6;

  // Opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_OVERLAPPED_MASK = 2'd0;
  localparam logic [1:0] CFG_DUP_MASK        = 2'd1;
  localparam logic [1:0] CFG_CONSOLE_TYPE    = 2'd2;

  // Handle low bits
  localparam logic [1:0] HANDLE_TAG = 2'b11;

  // Request payload
  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        handle_in;
    logic [5:0]         new_type;
    logic signed [31:0] new_descriptor;
    logic [63:0]        new_data;
    logic [7:0]         new_flags;
  } htf_req_t;

  // Response payload
  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        handle_out;
    logic [5:0]         entry_type;
    logic signed [31:0] entry_descriptor;
    logic [63:0]        entry_data;
    logic               is_overlapped;
    logic               is_dup;
    logic               do_close_descriptor;
    logic               do_unmap;
    logic               do_release_data;
  } htf_rsp_t;

  // One slot of the handle table
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] desc;
    logic [63:0] data;
    logic [7:0]  flags;
  } htf_slot_t;

endpackage

`default_nettype wire

// ===== sv/handle_table_freelist_core.sv =====
// Handle table with a LIFO free-slot stack, top level.
// Holds the slot memory, the free-index stack memory and the request sequencer.
// Depends on htf_pkg.
//
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with an htf_req_t payload:
//   allocate, close or query. Each request gives exactly one response on
//   out_valid_o/out_ready_i. On accept the request is registered together
//   with synchronous reads of the slot memory (used by close/query) and of the
//   free stack (used by allocate); in the execute state the sequencer then
//   writes back and loads the response register, and returns to idle before the
//   next request is taken, so a request is not accepted while another executes.
//   The response register decouples the sides: a request is taken while an
//   earlier response still waits; when the receiver stalls, the working
//   request holds in the execute state until the response register frees up.
//   The cfg channel (index, 8-bit data) is always ready and writes the
//   overlapped mask, the dup mask and the console type; write it only idle.
//   Reset is asynchronous and immediate: no clearing pass. Untouched table
//   and stack entries are recognized from the low-water mark of the free count.
`default_nettype none

module handle_table_freelist_core #(
  parameter int unsigned TABLE_SLOTS = htf_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire htf_pkg::htf_req_t in_req_i,
  // response channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output htf_pkg::htf_rsp_t      out_rsp_o,
  // configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);

  // Sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Configuration registers
  logic [7:0] ovl_mask_q;
  logic [7:0] dup_mask_q;
  logic [5:0] console_type_q;

  // Free count and its low-water mark
  logic [CNT_W-1:0] free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0] low_mark_q, low_mark_d;

  // Request payload register
  htf_pkg::htf_req_t req_q;
  logic [IDX_W-1:0]  pop_pos_q;

  // Memories
  htf_pkg::htf_slot_t slot_mem [TABLE_SLOTS];
  logic [IDX_W-1:0]   stack_mem [TABLE_SLOTS];
  htf_pkg::htf_slot_t slot_rd_q;
  logic [IDX_W-1:0]   stack_rd_q;

  // Response register
  logic              out_valid_q;
  htf_pkg::htf_rsp_t rsp_q, rsp_d;

  // Write-back controls
  logic               slot_we;
  logic [IDX_W-1:0]   slot_wa;
  htf_pkg::htf_slot_t slot_wd;
  logic               stack_we;
  logic [IDX_W-1:0]   stack_wa;

  logic in_fire, exec_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign exec_fire   = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovl_mask_q     <= 8'd1;
      dup_mask_q     <= 8'd2;
      console_type_q <= 6'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        htf_pkg::CFG_OVERLAPPED_MASK: ovl_mask_q     <= cfg_data_i;
        htf_pkg::CFG_DUP_MASK:        dup_mask_q     <= cfg_data_i;
        htf_pkg::CFG_CONSOLE_TYPE:    console_type_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EXEC;
      S_EXEC:  if (exec_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_cnt_q  <= CNT_W'(TABLE_SLOTS - htf_pkg::STD_SLOTS);
      low_mark_q  <= CNT_W'(TABLE_SLOTS - htf_pkg::STD_SLOTS);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        free_cnt_q  <= free_cnt_d;
        low_mark_q  <= low_mark_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture and memory reads on accept
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q      <= in_req_i;
      pop_pos_q  <= IDX_W'(free_cnt_q - CNT_W'(1));
      slot_rd_q  <= slot_mem[in_req_i.handle_in[IDX_W+1:2]];
      stack_rd_q <= stack_mem[IDX_W'(free_cnt_q - CNT_W'(1))];
    end
  end

  // Memory write-back
  always_ff @(posedge clk_i) begin
    if (exec_fire && slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (exec_fire && stack_we) begin
      stack_mem[stack_wa] <= req_q.handle_in[IDX_W+1:2];
    end
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      rsp_q <= rsp_d;
    end
  end

  // Execute: decode, evaluate entry, build response and write-back
  logic [IDX_W-1:0]   idx;
  logic               handle_ok;
  logic               is_std;
  logic               untouched;
  logic [IDX_W-1:0]   pop_slot;
  htf_pkg::htf_slot_t entry;
  logic               dup;
  logic               unmap;
  logic               data_nz;

  always_comb begin
    idx       = req_q.handle_in[IDX_W+1:2];
    handle_ok = (req_q.handle_in[1:0] == htf_pkg::HANDLE_TAG) &&
                (req_q.handle_in[31:2] < 30'(TABLE_SLOTS));
    is_std    = (idx < IDX_W'(htf_pkg::STD_SLOTS));
    // slots at or above TABLE_SLOTS - low mark were never handed out
    untouched = ({1'b0, CNT_W'(idx)} + {1'b0, low_mark_q}) >= (CNT_W+1)'(TABLE_SLOTS);
    // stack positions below the low mark still hold their reset index
    pop_slot  = (CNT_W'(pop_pos_q) < low_mark_q) ?
                (IDX_W'(TABLE_SLOTS - 1) - pop_pos_q) : stack_rd_q;

    if (is_std) begin
      entry.kind  = console_type_q;
      entry.desc  = 32'(idx);
      entry.data  = '0;
      entry.flags = '0;
    end else if (untouched) begin
      entry = '0;
    end else begin
      entry = slot_rd_q;
    end

    dup     = |(entry.flags & dup_mask_q);
    data_nz = |entry.data;
    unmap   = (entry.desc == htf_pkg::DESC_SHARED_PAGE) && data_nz;

    rsp_d      = '0;
    slot_we    = 1'b0;
    slot_wa    = idx;
    slot_wd    = '0;
    stack_we   = 1'b0;
    stack_wa   = IDX_W'(free_cnt_q);
    free_cnt_d = free_cnt_q;
    low_mark_d = low_mark_q;

    case (req_q.opcode)
      htf_pkg::OP_ALLOC: begin
        if (free_cnt_q == '0) begin
          rsp_d.status     = htf_pkg::ST_FULL;
          rsp_d.handle_out = '1;
        end else begin
          rsp_d.status     = htf_pkg::ST_OK;
          rsp_d.handle_out = 32'({pop_slot, htf_pkg::HANDLE_TAG});
          slot_we          = 1'b1;
          slot_wa          = pop_slot;
          slot_wd.kind     = req_q.new_type;
          slot_wd.desc     = req_q.new_descriptor;
          slot_wd.data     = req_q.new_data;
          slot_wd.flags    = req_q.new_flags;
          free_cnt_d       = free_cnt_q - CNT_W'(1);
          if (free_cnt_d < low_mark_q) begin
            low_mark_d = free_cnt_d;
          end
        end
      end
      htf_pkg::OP_CLOSE, htf_pkg::OP_QUERY: begin
        if (!handle_ok || entry.kind == '0) begin
          rsp_d.status = htf_pkg::ST_BAD;
        end else begin
          rsp_d.status           = htf_pkg::ST_OK;
          rsp_d.entry_type       = entry.kind;
          rsp_d.entry_descriptor = entry.desc;
          rsp_d.entry_data       = entry.data;
          rsp_d.is_overlapped    = |(entry.flags & ovl_mask_q);
          rsp_d.is_dup           = dup;
          // close of a regular slot: clear it and, while the count is below TABLE_SLOTS, push it back
          if (req_q.opcode == htf_pkg::OP_CLOSE && !is_std) begin
            slot_we = 1'b1;
            if (free_cnt_q < CNT_W'(TABLE_SLOTS)) begin
              stack_we   = 1'b1;
              free_cnt_d = free_cnt_q + CNT_W'(1);
            end
            if (!dup) begin
              rsp_d.do_close_descriptor = !entry.desc[31];
              rsp_d.do_unmap            = unmap;
              rsp_d.do_release_data     = data_nz && !unmap;
            end
          end
        end
      end
      default: begin
        rsp_d.status = htf_pkg::ST_BAD;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Free count never exceeds the slots outside the standard range
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CNT_W'(TABLE_SLOTS - htf_pkg::STD_SLOTS))
    else $error("free count above number of regular slots");

  // Low-water mark never above the current count
  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_mark_q <= free_cnt_q)
    else $error("low mark above free count");

  // A successful allocate pops exactly one stack entry
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && req_q.opcode == htf_pkg::OP_ALLOC && free_cnt_q != '0) |=>
    (free_cnt_q == $past(free_cnt_q) - CNT_W'(1)))
    else $error("allocate did not pop one entry");

  // An allocated handle never names a standard slot
  a_no_std_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && req_q.opcode == htf_pkg::OP_ALLOC && free_cnt_q != '0) |->
    (pop_slot >= IDX_W'(htf_pkg::STD_SLOTS)))
    else $error("allocate handed out a standard slot");

  // A new request is taken only after the previous one finished execution
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_EXEC && !in_ready_o))
    else $error("request taken while another executes");
`endif

endmodule

`default_nettype wire
